// ===== sv/b64enc_pkg.sv =====
`timescale 1ns / 1ps
package b64enc_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [6:0] PAD_CODE = 7'd61;

  localparam logic [1:0] NBYTES_ONE   = 2'd1;
  localparam logic [1:0] NBYTES_TWO   = 2'd2;
  localparam logic [1:0] NBYTES_THREE = 2'd3;

  localparam logic [1:0] POS_START = 2'd0;
  localparam logic [1:0] POS_ONE   = 2'd1;
  localparam logic [1:0] POS_TWO   = 2'd2;

  localparam logic [1:0] CHAR_IDX_LAST = 2'd3;

  // one complete or padded group waiting to be serialised
  typedef struct packed {
    logic [23:0] bits;
    logic [1:0]  nbytes;
    logic        last;
  } group_t;

  typedef struct packed {
    logic [1:0] pos;
    logic       push;
  } front_status_t;

  typedef struct packed {
    logic                   full;
    logic                   empty;
    logic [QUEUE_CNT_W-1:0] count;
  } queue_status_t;

  // standard alphabet lookup
  function automatic logic [6:0] b64_char(input logic [5:0] v);
    logic [6:0] v7;
    v7 = {1'b0, v};
    if (v < 6'd26) begin
      return v7 + 7'd65;
    end else if (v < 6'd52) begin
      return v7 + 7'd71;
    end else if (v < 6'd62) begin
      return v7 - 7'd4;
    end else if (v == 6'd62) begin
      return 7'd43;
    end else begin
      return 7'd47;
    end
  endfunction

endpackage

// ===== sv/b64enc_front.sv =====
`timescale 1ns / 1ps
module b64enc_front import b64enc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    data_byte,
  input  logic          final_byte,
  input  logic          queue_full,
  output group_t        push_group,
  output front_status_t status
);

  logic [15:0] pending;
  logic [1:0]  pos;
  logic [23:0] bits;
  logic [1:0]  nbytes;
  logic        accept;
  logic        push;

  always_comb begin
    case (pos)
      POS_ONE: begin
        bits   = {pending[15:8], data_byte, 8'h00};
        nbytes = NBYTES_TWO;
      end
      POS_TWO: begin
        bits   = {pending, data_byte};
        nbytes = NBYTES_THREE;
      end
      default: begin
        bits   = {data_byte, 16'h0000};
        nbytes = NBYTES_ONE;
      end
    endcase
  end

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && ((nbytes == NBYTES_THREE) || final_byte);

  assign push_group.bits   = bits;
  assign push_group.nbytes = nbytes;
  assign push_group.last   = final_byte;

  assign status.pos  = pos;
  assign status.push = push;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 16'h0000;
      pos     <= POS_START;
    end else if (accept) begin
      if (push) begin
        pending <= 16'h0000;
        pos     <= POS_START;
      end else begin
        pending <= bits[23:8];
        pos     <= nbytes;
      end
    end
  end

endmodule

// ===== sv/b64enc_queue.sv =====
`timescale 1ns / 1ps
module b64enc_queue import b64enc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  group_t        push_group,
  input  logic          pop,
  output group_t        head,
  output queue_status_t status
);

  group_t                 entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   do_push;
  logic                   do_pop;

  assign status.full  = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign status.count = count;
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_group;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/b64enc_back.sv =====
`timescale 1ns / 1ps
module b64enc_back import b64enc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  group_t     head,
  input  logic       queue_empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] char_code,
  output logic       end_of_text
);

  group_t     held;
  logic       busy;
  logic [1:0] idx;
  group_t     cur;
  logic [1:0] cur_idx;
  logic       advance;
  logic       emit;
  logic [5:0] sextet;
  logic [6:0] code;
  logic       pad;

  assign advance = !out_valid || out_ready;
  assign emit    = advance && (busy || !queue_empty);
  assign pop     = advance && !busy && !queue_empty;
  assign cur     = busy ? held : head;
  assign cur_idx = busy ? idx : 2'd0;

  always_comb begin
    case (cur_idx)
      2'd0:    sextet = cur.bits[23:18];
      2'd1:    sextet = cur.bits[17:12];
      2'd2:    sextet = cur.bits[11:6];
      default: sextet = cur.bits[5:0];
    endcase
    pad  = ((cur_idx == 2'd2) && (cur.nbytes == NBYTES_ONE)) ||
           ((cur_idx == CHAR_IDX_LAST) && (cur.nbytes != NBYTES_THREE));
    code = pad ? PAD_CODE : b64_char(sextet);
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      char_code   <= code;
      end_of_text <= (cur_idx == CHAR_IDX_LAST) && cur.last;
    end
    if (pop) begin
      held <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      busy      <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (advance) begin
        out_valid <= emit;
      end
      if (emit) begin
        busy <= (cur_idx != CHAR_IDX_LAST);
        idx  <= cur_idx + 2'd1;
      end
    end
  end

endmodule

// ===== sv/base64_stream_encoder_core.sv =====
`timescale 1ns / 1ps
// channel  | handshake           | payload
// input    | in_valid, in_ready  | data_byte[7:0], final_byte
// output   | out_valid, out_ready| char_code[6:0], end_of_text
//
// a byte is taken every cycle while the group queue has room; a group's
// four characters leave one per cycle from the output register while
// out_ready allows, so the single output port sets the sustained byte rate
// the byte that closes a group is written into the queue, then its first character is registered at the output
// reset clears the group position, the queue pointers and the output valid
// either side may stall alone: the two-entry queue holds finished groups
module base64_stream_encoder_core import b64enc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] char_code,
  output logic       end_of_text
);

  group_t        push_group;
  group_t        head;
  front_status_t front_status;
  queue_status_t queue_status;
  logic          pop;

  b64enc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .queue_full (queue_status.full),
    .push_group (push_group),
    .status     (front_status)
  );

  b64enc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (front_status.push),
    .push_group (push_group),
    .pop        (pop),
    .head       (head),
    .status     (queue_status)
  );

  b64enc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .queue_empty (queue_status.empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .char_code   (char_code),
    .end_of_text (end_of_text)
  );

  // group position never reaches the unused code
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    front_status.pos != 2'd3)
    else $error("group position out of range");

  // a completed group is only produced when the queue can take it
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    front_status.push |-> !queue_status.full)
    else $error("group pushed into full queue");

  // queue occupancy stays within its depth
  a_queue_count: assert property (@(posedge clk) disable iff (rst)
    queue_status.count <= QUEUE_CNT_W'(QUEUE_DEPTH))
    else $error("queue count overflow");

  // a pop always leaves a fresh character in the output register
  a_pop_emits: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid)
    else $error("group popped without output");

endmodule
